// ----- sv/udff_pkg.sv -----
// ----------------------------------------------------------------------------
// udff_pkg: shared types and constants for the decimal field formatter
// Segment codes, controller states, command/status words and the table of
// decimal multiples used by the digit extractor.
// ----------------------------------------------------------------------------
package udff_pkg;

  localparam int unsigned MAX_FIELD  = 48;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned NUM_SEGS   = 7;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // output order of the formatted field
  typedef enum logic [2:0] {
    SEG_LSPACE = 3'd0,
    SEG_PLUS   = 3'd1,
    SEG_LZERO  = 3'd2,
    SEG_SPACE  = 3'd3,
    SEG_PREC   = 3'd4,
    SEG_DIGITS = 3'd5,
    SEG_RPAD   = 3'd6
  } seg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_PLAN,
    S_FIRST,
    S_EMIT,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic plan;
    logic first;
    logic emit;
    logic empty;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic seg_found;
    logic last;
    logic out_free;
  } status_t;

  // k * 10^p for p, k in 0..9; 9e9 needs 34 bits
  typedef logic [NUM_DIGITS-1:0][NUM_DIGITS-1:0][33:0] mult_tab_t;

  function automatic mult_tab_t build_mult_tab();
    mult_tab_t   t;
    logic [33:0] pw;
    pw = 34'd1;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        t[p][k] = 34'(k) * pw;
      end
      pw = pw * 34'd10;
    end
    return t;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

// ----- sv/udff_ctrl.sv -----
// ----------------------------------------------------------------------------
// udff_ctrl: sequencing controller
// Walks one word through capture, digit extraction, planning and character
// output, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module udff_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  udff_pkg::status_t status,
  output udff_pkg::cmd_t    cmd
);
  import udff_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CONV;
      end
      S_CONV: begin
        if (status.conv_done) state_next = S_PLAN;
      end
      S_PLAN: begin
        state_next = S_FIRST;
      end
      S_FIRST: begin
        state_next = status.seg_found ? S_EMIT : S_EMPTY;
      end
      S_EMIT: begin
        if (status.out_free && status.last) state_next = S_IDLE;
      end
      S_EMPTY: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_CONV:  cmd.conv  = 1'b1;
      S_PLAN:  cmd.plan  = 1'b1;
      S_FIRST: cmd.first = 1'b1;
      S_EMIT:  cmd.emit  = status.out_free;
      S_EMPTY: cmd.empty = status.out_free;
      default: cmd = '0;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.conv, cmd.plan, cmd.first, cmd.emit, cmd.empty}))
    else $error("more than one datapath command at once");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CONV)
    else $error("captured word did not start conversion");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("input taken while a word is in flight");

endmodule

// ----- sv/udff_dp.sv -----
// ----------------------------------------------------------------------------
// udff_dp: formatter datapath
// Input capture, one decimal digit per cycle (most significant first),
// segment length planning, segment walker and the output register.
// ----------------------------------------------------------------------------
module udff_dp (
  input  logic              clk,
  input  logic              rst,
  input  udff_pkg::cmd_t    cmd,
  output udff_pkg::status_t status,
  input  logic [31:0]       number,
  input  logic [5:0]        field_width,
  input  logic [5:0]        precision,
  input  logic              precision_given,
  input  logic              left_align,
  input  logic              zero_pad,
  input  logic              force_plus,
  input  logic              space_sign,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              has_char,
  output logic              is_last,
  output logic [31:0]       total_written
);
  import udff_pkg::*;

  // captured word
  logic [31:0] rem;
  logic [5:0]  wi, pre;
  logic        pg, left, zpad, plus, space, is_zero;

  // conversion
  logic [3:0]  pos;
  logic [39:0] digs;
  logic [3:0]  ndig;
  logic        seen;
  logic [3:0]  digit;
  logic [33:0] sub;

  // plan and walker
  logic [NUM_SEGS-1:0][5:0] lens;
  logic [NUM_SEGS-1:0]      nz;
  seg_t        seg;
  logic [5:0]  cnt;
  seg_t        nxt;
  logic        found;

  logic [31:0] count;
  logic        out_free;

  // --- digit extraction: largest k with k*10^pos <= rem
  always_comb begin
    digit = 4'd0;
    for (int k = 1; k < NUM_DIGITS; k++) begin
      if ({2'b00, rem} >= MULT_TAB[pos][k]) digit = 4'(k);
    end
    sub = MULT_TAB[pos][digit];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem     <= number;
      wi      <= (field_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : field_width;
      pre     <= (precision > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : precision;
      pg      <= precision_given;
      left    <= left_align;
      zpad    <= zero_pad;
      plus    <= force_plus;
      space   <= space_sign;
      is_zero <= (number == 32'd0);
      pos     <= 4'(NUM_DIGITS - 1);
      ndig    <= 4'd1;
      seen    <= 1'b0;
    end else if (cmd.conv) begin
      rem  <= 32'({2'b00, rem} - sub);
      digs <= {digs[35:0], digit};
      pos  <= pos - 4'd1;
      if (digit != 4'd0 && !seen) begin
        ndig <= pos + 4'd1;
        seen <= 1'b1;
      end
    end
  end

  // --- segment lengths
  logic       zc, zp_eff;
  logic [3:0] slen;
  logic [5:0] body;
  logic [6:0] nb;
  logic [5:0] pad;

  always_comb begin
    zc     = is_zero && pg && (pre == 6'd0);
    zp_eff = zpad && !pg;
    slen   = zc ? 4'd0 : ndig;
    if (zc)                          body = 6'd0;
    else if (pg && pre > {2'b00, ndig}) body = pre;
    else                             body = {2'b00, ndig};
    nb  = {1'b0, body} + 7'(plus | space);
    pad = (nb < {1'b0, wi}) ? 6'({1'b0, wi} - nb) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      lens[SEG_LSPACE] <= (!left && !zp_eff) ? pad : 6'd0;
      lens[SEG_PLUS]   <= {5'd0, plus};
      lens[SEG_LZERO]  <= (!left && zp_eff) ? pad : 6'd0;
      lens[SEG_SPACE]  <= {5'd0, space};
      lens[SEG_PREC]   <= (pg && pre > {2'b00, slen}) ? 6'(pre - {2'b00, slen}) : 6'd0;
      lens[SEG_DIGITS] <= {2'b00, slen};
      lens[SEG_RPAD]   <= left ? pad : 6'd0;
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_SEGS; j++) begin
      nz[j] = (lens[j] != 6'd0);
    end
  end

  // next non-empty segment after the current one (or from the start)
  always_comb begin
    nxt   = SEG_LSPACE;
    found = 1'b0;
    for (int j = NUM_SEGS - 1; j >= 0; j--) begin
      if (nz[j] && (cmd.first || 3'(j) > seg)) begin
        nxt   = seg_t'(3'(j));
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first) begin
      seg <= nxt;
      cnt <= lens[nxt];
    end else if (cmd.emit) begin
      if (cnt != 6'd1) begin
        cnt <= cnt - 6'd1;
      end else begin
        seg <= nxt;
        cnt <= lens[nxt];
      end
    end
  end

  // --- character of the current segment
  logic [3:0] didx;
  logic [7:0] ch;

  always_comb begin
    didx = cnt[3:0] - 4'd1;
    case (seg)
      SEG_LSPACE: ch = CH_SPACE;
      SEG_PLUS:   ch = CH_PLUS;
      SEG_LZERO:  ch = CH_ZERO;
      SEG_SPACE:  ch = CH_SPACE;
      SEG_PREC:   ch = CH_ZERO;
      SEG_DIGITS: ch = CH_ZERO | {4'd0, digs[didx*4 +: 4]};
      SEG_RPAD:   ch = zp_eff ? CH_ZERO : CH_SPACE;
      default:    ch = CH_SPACE;
    endcase
  end

  // --- output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= 32'd0;
    end else begin
      if (cmd.emit || cmd.empty) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) count <= count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char      <= ch;
      has_char      <= 1'b1;
      is_last       <= (cnt == 6'd1) && !found;
      total_written <= count + 32'd1;
    end else if (cmd.empty) begin
      out_char      <= CH_NONE;
      has_char      <= 1'b0;
      is_last       <= 1'b1;
      total_written <= count;
    end
  end

  assign status.conv_done = (pos == 4'd0);
  assign status.seg_found = found;
  assign status.last      = (cnt == 6'd1) && !found;
  assign status.out_free  = out_free;

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> cnt != 6'd0)
    else $error("character emitted from an empty segment");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> total_written == $past(count) + 32'd1 && count == total_written)
    else $error("running total out of step with emitted word");

  a_empty_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.empty |=> $stable(count) && !has_char && is_last)
    else $error("empty result changed the running total");

endmodule

// ----- sv/unsigned_decimal_field_formatter.sv -----
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter: printf-style %u field formatter
// Formats a 32-bit unsigned number as a padded decimal ASCII field.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one word: number, width, precision
// and flags. Output channel (out_valid/out_stall) gives one character per
// word in field order; is_last marks the final one. A field that prints
// nothing gives a single word with has_char low. total_written is the
// running count of characters, which wraps at 2^32.
// After acceptance the decimal digits are extracted, one digit per cycle from
// the most significant; the segment lengths are then planned and the first
// segment is selected. Characters then leave at one per cycle through the
// output register while the output is not stalled. An item gives N results,
// N from 1 to 50; in_stall stays high until the last result is issued.
// A stall on the output holds the output register and the segment walker.
// Reset clears the controller, the output valid and the running count.
// ----------------------------------------------------------------------------
module unsigned_decimal_field_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] number,
  input  logic [5:0]  field_width,
  input  logic [5:0]  precision,
  input  logic        precision_given,
  input  logic        left_align,
  input  logic        zero_pad,
  input  logic        force_plus,
  input  logic        space_sign,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        has_char,
  output logic        is_last,
  output logic [31:0] total_written
);
  import udff_pkg::*;

  cmd_t    cmd;
  status_t status;

  udff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  udff_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .number          (number),
    .field_width     (field_width),
    .precision       (precision),
    .precision_given (precision_given),
    .left_align      (left_align),
    .zero_pad        (zero_pad),
    .force_plus      (force_plus),
    .space_sign      (space_sign),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .has_char        (has_char),
    .is_last         (is_last),
    .total_written   (total_written)
  );

endmodule
